// File: src/pbwf_pkg.sv
package pbwf_pkg;

    localparam int unsigned VarintMaxBytes = 10;

    localparam int unsigned InDataWidth  = 8;
    localparam int unsigned InUserWidth  = 1;
    localparam int unsigned OutDataWidth = 96;
    localparam int unsigned OutUserWidth = 3;

    localparam int unsigned FieldWidth = 29;
    localparam int unsigned TypeWidth  = 3;
    localparam int unsigned ValueWidth = 64;
    localparam int unsigned CountWidth = 4;
    localparam int unsigned LenWidth   = 32;

    localparam logic [1:0] KIND_SCALAR  = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic ERR_WIRE_TYPE  = 1'b0;
    localparam logic ERR_VARINT_LEN = 1'b1;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

endpackage

// File: src/protobuf_wire_field_parser_top.sv
// Channel   Direction  tdata                              tuser                     tlast
// s_axis    in         [7:0] in_byte                      [0] msg_start             -
// m_axis    out        [28:0] field_number,               [1:0] result_kind,        payload_last
//                      [31:29] wire_type,                 [2] error_code
//                      [95:32] field_value
//
// One byte is taken per cycle while m_axis is not stalled, and each byte yields at most one result transfer.
// A byte passes an input register, then one decode step, then the output register,
// which offers its result; a stall on the output can hold it in either register.
// The rate is set by the single decode step that updates the varint accumulator.
// Reset is synchronous and active low; the parser then expects a tag.
// A stall on m_axis freezes the decode step; s_axis keeps taking a byte while the
// input register is empty.
module protobuf_wire_field_parser_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] in_byte
    input  logic [pbwf_pkg::InDataWidth-1:0]      s_axis_tdata,
    // [0] msg_start
    input  logic [pbwf_pkg::InUserWidth-1:0]      s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [28:0] field_number, [31:29] wire_type, [95:32] field_value
    output logic [pbwf_pkg::OutDataWidth-1:0]     m_axis_tdata,
    // [1:0] result_kind, [2] error_code
    output logic [pbwf_pkg::OutUserWidth-1:0]     m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import pbwf_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_VARINT,
        PH_FIX64,
        PH_FIX32,
        PH_LEN,
        PH_PAYLOAD,
        PH_HOLD
    } t_phase;

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_start;

    t_phase                 r_phase, n_phase;
    logic [ValueWidth-1:0]  r_acc, n_acc;
    logic [CountWidth-1:0]  r_cnt, n_cnt;
    logic [FieldWidth-1:0]  r_field, n_field;
    logic [TypeWidth-1:0]   r_type, n_type;
    logic [LenWidth-1:0]    r_left, n_left;

    logic                   r_out_valid;
    logic [1:0]             r_out_kind;
    logic [FieldWidth-1:0]  r_out_field;
    logic [TypeWidth-1:0]   r_out_type;
    logic [ValueWidth-1:0]  r_out_value;
    logic                   r_out_last;
    logic                   r_out_err;

    logic                   w_adv;
    logic                   w_fire;
    t_phase                 w_phase;
    logic [ValueWidth-1:0]  w_acc;
    logic [CountWidth-1:0]  w_cnt;
    logic [6:0]             w_vsh;
    logic [ValueWidth-1:0]  w_vacc;
    logic [ValueWidth-1:0]  w_facc;
    logic [CountWidth-1:0]  w_cnt_inc;
    logic                   w_vdone;
    logic                   w_vlong;
    logic [LenWidth-1:0]    w_left_dec;

    logic                   w_res_valid;
    logic [1:0]             w_res_kind;
    logic [FieldWidth-1:0]  w_res_field;
    logic [TypeWidth-1:0]   w_res_type;
    logic [ValueWidth-1:0]  w_res_value;
    logic                   w_res_last;
    logic                   w_res_err;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    assign w_phase = r_in_start ? PH_TAG : r_phase;
    assign w_acc   = r_in_start ? '0 : r_acc;
    assign w_cnt   = r_in_start ? '0 : r_cnt;

    assign w_vsh      = 7'(w_cnt) * 7'd7;
    assign w_vacc     = w_vsh[6] ? w_acc
                                 : (w_acc | (ValueWidth'(r_in_byte[6:0]) << w_vsh[5:0]));
    assign w_facc     = w_acc | (ValueWidth'(r_in_byte) << {w_cnt[2:0], 3'b000});
    assign w_cnt_inc  = w_cnt + 1'b1;
    assign w_vdone    = !r_in_byte[7];
    assign w_vlong    = r_in_byte[7] && (w_cnt_inc >= CountWidth'(VarintMaxBytes));
    assign w_left_dec = r_left - 1'b1;

    always_comb begin
        n_phase     = w_phase;
        n_acc       = w_acc;
        n_cnt       = w_cnt;
        n_field     = r_field;
        n_type      = r_type;
        n_left      = r_left;
        w_res_valid = 1'b0;
        w_res_kind  = KIND_SCALAR;
        w_res_field = r_field;
        w_res_type  = r_type;
        w_res_value = '0;
        w_res_last  = 1'b0;
        w_res_err   = ERR_WIRE_TYPE;
        case (w_phase)
            PH_TAG: begin
                n_acc = w_vacc;
                n_cnt = w_cnt_inc;
                if (w_vdone) begin
                    n_type  = w_vacc[2:0];
                    n_field = w_vacc[31:3];
                    n_acc   = '0;
                    n_cnt   = '0;
                    case (w_vacc[2:0])
                        WT_VARINT: n_phase = PH_VARINT;
                        WT_FIX64:  n_phase = PH_FIX64;
                        WT_LEN:    n_phase = PH_LEN;
                        WT_FIX32:  n_phase = PH_FIX32;
                        default: begin
                            n_phase     = PH_HOLD;
                            w_res_valid = 1'b1;
                            w_res_kind  = KIND_ERROR;
                            w_res_field = w_vacc[31:3];
                            w_res_type  = w_vacc[2:0];
                            w_res_err   = ERR_WIRE_TYPE;
                        end
                    endcase
                end else if (w_vlong) begin
                    n_phase     = PH_HOLD;
                    w_res_valid = 1'b1;
                    w_res_kind  = KIND_ERROR;
                    w_res_field = '0;
                    w_res_type  = '0;
                    w_res_err   = ERR_VARINT_LEN;
                end
            end
            PH_VARINT, PH_LEN: begin
                n_acc = w_vacc;
                n_cnt = w_cnt_inc;
                if (w_vdone) begin
                    w_res_valid = 1'b1;
                    n_acc       = '0;
                    n_cnt       = '0;
                    if (w_phase == PH_VARINT) begin
                        w_res_kind  = KIND_SCALAR;
                        w_res_value = w_vacc;
                        n_phase     = PH_TAG;
                    end else begin
                        w_res_kind  = KIND_HEADER;
                        w_res_value = ValueWidth'(w_vacc[LenWidth-1:0]);
                        n_left      = w_vacc[LenWidth-1:0];
                        n_phase     = (w_vacc[LenWidth-1:0] == '0) ? PH_TAG : PH_PAYLOAD;
                    end
                end else if (w_vlong) begin
                    n_phase     = PH_HOLD;
                    w_res_valid = 1'b1;
                    w_res_kind  = KIND_ERROR;
                    w_res_err   = ERR_VARINT_LEN;
                end
            end
            PH_FIX64, PH_FIX32: begin
                n_acc = w_facc;
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= ((w_phase == PH_FIX64) ? CountWidth'(8) : CountWidth'(4))) begin
                    w_res_valid = 1'b1;
                    w_res_kind  = KIND_SCALAR;
                    w_res_value = w_facc;
                    n_phase     = PH_TAG;
                    n_acc       = '0;
                    n_cnt       = '0;
                end
            end
            PH_PAYLOAD: begin
                n_left      = w_left_dec;
                w_res_valid = 1'b1;
                w_res_kind  = KIND_PAYLOAD;
                w_res_value = ValueWidth'(r_in_byte);
                w_res_last  = (w_left_dec == '0);
                if (w_left_dec == '0) begin
                    n_phase = PH_TAG;
                    n_acc   = '0;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_phase = PH_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_TAG;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_field     <= '0;
            r_type      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_fire) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_field <= n_field;
                r_type  <= n_type;
                r_left  <= n_left;
            end
            if (w_adv) begin
                r_out_valid <= w_fire && w_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser[0];
        end
        if (w_adv) begin
            r_out_kind  <= w_res_kind;
            r_out_field <= w_res_field;
            r_out_type  <= w_res_type;
            r_out_value <= w_res_value;
            r_out_last  <= w_res_last;
            r_out_err   <= w_res_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_value, r_out_type, r_out_field};
    assign m_axis_tuser  = {r_out_err, r_out_kind};
    assign m_axis_tlast  = r_out_last;

    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1:0] == KIND_PAYLOAD)
        else $error("Last marker on a result that is not a payload byte.");

    a_err_code_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == KIND_ERROR)
        else $error("Varint error code on a non-error result.");

    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_res_valid && w_res_kind == KIND_ERROR |=> r_phase == PH_HOLD)
        else $error("Parser did not hold after an error result.");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_left != '0)
        else $error("Payload phase with no bytes left.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HOLD |-> r_cnt < CountWidth'(VarintMaxBytes))
        else $error("Byte count reached the varint limit without an error.");

endmodule

// File: bench/protobuf_wire_field_parser_top_tb.sv
`timescale 1ns / 1ps

module protobuf_wire_field_parser_top_tb;
    import pbwf_pkg::*;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned PhaseItems = 580;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_VARINT,
        PH_FIX64,
        PH_FIX32,
        PH_LEN,
        PH_PAYLOAD,
        PH_HOLD
    } t_parse_phase;

    typedef enum int {
        VARINT_MORE,
        VARINT_DONE,
        VARINT_TOO_LONG
    } t_varint_step;

    typedef struct packed {
        logic [1:0]            kind;
        logic [FieldWidth-1:0] field_number;
        logic [TypeWidth-1:0]  wire_type;
        logic [ValueWidth-1:0] value;
        logic                  last;
        logic                  err;
    } t_field_result;

    typedef bit [7:0] t_octet_q[$];

    class t_field_scoreboard;
        t_parse_phase          phase;
        bit [ValueWidth-1:0]   acc;
        bit [CountWidth-1:0]   count;
        bit [FieldWidth-1:0]   field_num;
        bit [TypeWidth-1:0]    wire_type;
        bit [LenWidth-1:0]     bytes_left;
        t_field_result         pending_results[$];
        int                    mismatches;

        function new();
            phase = PH_TAG;
            acc = '0;
            count = '0;
            field_num = '0;
            wire_type = '0;
            bytes_left = '0;
            mismatches = 0;
        endfunction

        function void restart(t_parse_phase next);
            phase = next;
            acc = '0;
            count = '0;
        endfunction

        function void expect_result(logic [1:0] kind, logic [ValueWidth-1:0] value, logic last,
                                    logic err);
            t_field_result r;
            r.kind = kind;
            r.field_number = field_num;
            r.wire_type = wire_type;
            r.value = value;
            r.last = last;
            r.err = err;
            pending_results.push_back(r);
        endfunction

        function t_varint_step take_varint(bit [7:0] b);
            int shift;
            shift = 7 * int'(count);
            if (shift < 64) begin
                acc |= {57'b0, b[6:0]} << shift;
            end
            count = count + 1'b1;
            if (!b[7]) begin
                return VARINT_DONE;
            end
            if (count >= VarintMaxBytes) begin
                return VARINT_TOO_LONG;
            end
            return VARINT_MORE;
        endfunction

        function void note_byte(bit [7:0] b, bit msg_start);
            t_varint_step step;
            int shift;
            if (msg_start) begin
                restart(PH_TAG);
            end
            case (phase)
                PH_TAG: begin
                    step = take_varint(b);
                    if (step == VARINT_TOO_LONG) begin
                        phase = PH_HOLD;
                        field_num = '0;
                        wire_type = '0;
                        expect_result(KIND_ERROR, '0, 1'b0, ERR_VARINT_LEN);
                    end else if (step == VARINT_DONE) begin
                        wire_type = acc[2:0];
                        field_num = acc[31:3];
                        case (wire_type)
                            WT_VARINT: restart(PH_VARINT);
                            WT_FIX64:  restart(PH_FIX64);
                            WT_LEN:    restart(PH_LEN);
                            WT_FIX32:  restart(PH_FIX32);
                            default: begin
                                phase = PH_HOLD;
                                expect_result(KIND_ERROR, '0, 1'b0, ERR_WIRE_TYPE);
                            end
                        endcase
                    end
                end
                PH_VARINT, PH_LEN: begin
                    step = take_varint(b);
                    if (step == VARINT_TOO_LONG) begin
                        phase = PH_HOLD;
                        expect_result(KIND_ERROR, '0, 1'b0, ERR_VARINT_LEN);
                    end else if (step == VARINT_DONE) begin
                        if (phase == PH_VARINT) begin
                            expect_result(KIND_SCALAR, acc, 1'b0, 1'b0);
                            restart(PH_TAG);
                        end else begin
                            bytes_left = acc[31:0];
                            expect_result(KIND_HEADER, {32'b0, bytes_left}, 1'b0, 1'b0);
                            if (bytes_left == 0) begin
                                restart(PH_TAG);
                            end else begin
                                phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_FIX64, PH_FIX32: begin
                    shift = (8 * int'(count)) & 63;
                    acc |= {56'b0, b} << shift;
                    count = count + 1'b1;
                    if (count >= ((phase == PH_FIX64) ? 8 : 4)) begin
                        expect_result(KIND_SCALAR, acc, 1'b0, 1'b0);
                        restart(PH_TAG);
                    end
                end
                PH_PAYLOAD: begin
                    bytes_left = bytes_left - 1'b1;
                    expect_result(KIND_PAYLOAD, {56'b0, b}, bytes_left == 0, 1'b0);
                    if (bytes_left == 0) begin
                        restart(PH_TAG);
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        endtask

        task check_result(logic [OutDataWidth-1:0] data, logic [OutUserWidth-1:0] user,
                          logic last);
            t_field_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", data[63:0], '0);
                return;
            end
            want = pending_results.pop_front();
            if (user[1:0] !== want.kind) begin
                report_mismatch("result kind", 64'(user[1:0]), 64'(want.kind));
            end
            if (data[28:0] !== want.field_number) begin
                report_mismatch("field number", 64'(data[28:0]), 64'(want.field_number));
            end
            if (data[31:29] !== want.wire_type) begin
                report_mismatch("wire type", 64'(data[31:29]), 64'(want.wire_type));
            end
            if (data[95:32] !== want.value) begin
                report_mismatch("field value", data[95:32], want.value);
            end
            if (last !== want.last) begin
                report_mismatch("payload last", 64'(last), 64'(want.last));
            end
            if (user[2] !== want.err) begin
                report_mismatch("error code", 64'(user[2]), 64'(want.err));
            end
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [7:0] in_byte
    logic [InDataWidth-1:0]  s_axis_tdata = '0;
    // [0] msg_start
    logic [InUserWidth-1:0]  s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [28:0] field_number, [31:29] wire_type, [95:32] field_value
    logic [OutDataWidth-1:0] m_axis_tdata;
    // [1:0] result_kind, [2] error_code
    logic [OutUserWidth-1:0] m_axis_tuser;
    logic                    m_axis_tlast;

    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_left = 0;
    bit                hold_request = 1'b0;
    int                sent_items = 0;
    int unsigned       cycles = 0;
    t_field_scoreboard sb;

    protobuf_wire_field_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // A long hold-off lets the output back up until the input side stalls.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(bit [7:0] b, bit msg_start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= msg_start;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        sb.note_byte(b, msg_start);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_list(t_octet_q q, bit first_start);
        foreach (q[i]) begin
            send_byte(q[i], first_start && i == 0);
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
    endtask

    function automatic int varint_total(bit [63:0] v, int too_long_pct);
        int n;
        n = 1;
        while (n < VarintMaxBytes && (v >> (7 * n)) != 0) begin
            n++;
        end
        if ($urandom_range(99) < too_long_pct) begin
            return VarintMaxBytes + $urandom_range(1, 2);
        end
        if ($urandom_range(99) < 8) begin
            n += $urandom_range(0, VarintMaxBytes - n);
        end
        return n;
    endfunction

    // The parser drops random groups past the ninth, bar the tenth's bit 0.
    function automatic void put_varint(ref t_octet_q q, input bit [63:0] v, input int total);
        bit [6:0] group;
        for (int k = 0; k < total; k++) begin
            if (k < 9) begin
                group = 7'(v >> (7 * k));
            end else begin
                group = 7'($urandom);
            end
            if (k == 9) begin
                group[0] = v[63];
            end
            q.push_back({k < total - 1, group});
        end
    endfunction

    function automatic bit build_field(ref t_octet_q q);
        bit [FieldWidth-1:0] fnum;
        bit [TypeWidth-1:0]  wt;
        bit [63:0]           tag;
        bit [63:0]           v;
        int                  total;
        int                  sel;
        int                  len;
        bit                  stop;
        case ($urandom_range(3))
            0: fnum = FieldWidth'($urandom_range(1, 15));
            1: fnum = FieldWidth'($urandom_range(0, 2047));
            2: fnum = FieldWidth'($urandom);
            default: fnum = $urandom_range(1) ? '1 : '0;
        endcase
        sel = $urandom_range(99);
        if (sel < 28) begin
            wt = WT_VARINT;
        end else if (sel < 43) begin
            wt = WT_FIX64;
        end else if (sel < 58) begin
            wt = WT_FIX32;
        end else if (sel < 92) begin
            wt = WT_LEN;
        end else begin
            do begin
                wt = TypeWidth'($urandom);
            end while (wt == WT_VARINT || wt == WT_FIX64 || wt == WT_LEN || wt == WT_FIX32);
        end
        tag = {32'b0, fnum, wt};
        if ($urandom_range(99) < 10) begin
            tag[63:32] = $urandom;
        end
        total = varint_total(tag, 1);
        put_varint(q, tag, total);
        stop = total > VarintMaxBytes;
        if (!stop) begin
            case (wt)
                WT_VARINT: begin
                    v = {$urandom, $urandom} >> $urandom_range(63);
                    total = varint_total(v, 3);
                    put_varint(q, v, total);
                    stop = total > VarintMaxBytes;
                end
                WT_FIX64: repeat (8) q.push_back(8'($urandom));
                WT_FIX32: repeat (4) q.push_back(8'($urandom));
                WT_LEN: begin
                    len = ($urandom_range(99) < 80) ? $urandom_range(0, 8) : $urandom_range(9, 40);
                    v = {(($urandom_range(99) < 5) ? $urandom : 32'd0), 32'(len)};
                    total = varint_total(v, 3);
                    put_varint(q, v, total);
                    stop = total > VarintMaxBytes;
                    if (!stop) begin
                        repeat (len) q.push_back(8'($urandom));
                    end
                end
                default: stop = 1'b1;
            endcase
        end
        return stop;
    endfunction

    task automatic send_message();
        t_octet_q q;
        bit       stop;
        int       cut;
        stop = 1'b0;
        if ($urandom_range(99) < 4) begin
            repeat ($urandom_range(1, 16)) send_byte(8'($urandom), $urandom_range(99) < 30);
            return;
        end
        repeat ($urandom_range(1, 6)) begin
            if (!stop) begin
                stop = build_field(q);
            end
        end
        if ($urandom_range(99) < 6) begin
            cut = $urandom_range(0, q.size() - 1);
            q = q[0:cut];
        end else if (stop) begin
            repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
        end
        send_list(q, 1'b1);
    endtask

    task automatic send_directed();
        t_octet_q q;
        q = '{8'h08, 8'h00, 8'h05, 8'hff, 8'hff, 8'hff, 8'hff, 8'h12, 8'h00,
              8'h1a, 8'h01, 8'hab, 8'hf8, 8'hff, 8'hff, 8'hff, 8'h0f, 8'h7f,
              8'h1b, 8'hee};
        send_list(q, 1'b1);
        q = {};
        repeat (VarintMaxBytes) q.push_back(8'h80);
        send_list(q, 1'b1);
    endtask

    initial begin
        int goal;
        bit paused;
        bit held;
        paused = 1'b0;
        held = 1'b0;
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 32;
        recv_idle_pct = 51;
        send_directed();
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 32;
                    recv_idle_pct = 51;
                end
                1: begin
                    send_idle_pct = 51;
                    recv_idle_pct = 32;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            goal = sent_items + PhaseItems;
            while (sent_items < goal) begin
                if (p == 0 && !paused && sent_items >= goal - PhaseItems / 2) begin
                    paused = 1'b1;
                    wait_for_results();
                end
                if (p == 2 && !held && sent_items >= goal - PhaseItems / 2) begin
                    held = 1'b1;
                    hold_request = 1'b1;
                end
                send_message();
            end
            wait_for_results();
        end
        repeat (8) @(negedge i_clk);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
